### hdl/lrc_timestamp_parser_assert.svh
`ifndef LRC_TIMESTAMP_PARSER_ASSERT_SVH
`define LRC_TIMESTAMP_PARSER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LRC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define LRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/lrc_ts_pkg.sv
package lrc_ts_pkg;

    localparam logic [15:0] LRC_MS_PER_MIN   = 16'd60000;
    localparam logic [9:0]  LRC_MS_PER_SEC   = 10'd1000;
    localparam logic [5:0]  LRC_SEC_LIMIT    = 6'd60;
    localparam logic [6:0]  LRC_FRAC_SCALE   = 7'd100;
    localparam logic [1:0]  LRC_FRAC_MAX_DIG = 2'd3;

    localparam logic [7:0]  LRC_CH_SPACE = 8'h20;
    localparam logic [7:0]  LRC_CH_HT    = 8'h09;
    localparam logic [7:0]  LRC_CH_CR    = 8'h0D;
    localparam logic [7:0]  LRC_CH_ZERO  = 8'h30;
    localparam logic [7:0]  LRC_CH_NINE  = 8'h39;
    localparam logic [7:0]  LRC_CH_COLON = 8'h3A;
    localparam logic [7:0]  LRC_CH_DOT   = 8'h2E;
    localparam logic [7:0]  LRC_CH_COMMA = 8'h2C;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last;
    } t_lrc_req;

    typedef struct packed {
        logic [62:0] time_ms;
        logic        valid_res;
    } t_lrc_res;

endpackage

### hdl/lrc_ts_core.sv
`include "lrc_timestamp_parser_assert.svh"

module lrc_ts_core
    import lrc_ts_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_step,
    input  t_lrc_req i_req,
    output t_lrc_res o_res
);

    localparam logic [1:0] PH_LEAD = 2'd0;
    localparam logic [1:0] PH_MIN  = 2'd1;
    localparam logic [1:0] PH_SEC  = 2'd2;
    localparam logic [1:0] PH_FRAC = 2'd3;

    logic [1:0]  r_phase, n_phase;
    logic [62:0] r_min_ms, n_min_ms;
    logic        r_big, n_big;
    logic [5:0]  r_sec, n_sec;
    logic [9:0]  r_frac, n_frac;
    logic [1:0]  r_fdig, n_fdig;
    logic        r_has, n_has;
    logic        r_space, n_space;
    logic        r_err, n_err;

    logic        is_ws;
    logic        is_digit;
    logic [3:0]  digit;
    logic [1:0]  cur_phase;
    logic [19:0] digit_ms;
    logic [67:0] min_prod;
    logic [9:0]  sec_prod;
    logic [13:0] frac_prod;
    logic [16:0] frac_ms;
    logic [16:0] rest_ms;
    logic [63:0] total;
    logic        parts_ok;
    logic        ok;

    // The minutes are kept already scaled to milliseconds, with a sticky flag once
    // that value no longer fits in 63 bits.
    always_comb begin
        is_ws     = (i_req.char_code == LRC_CH_SPACE) ||
                    (i_req.char_code inside {[LRC_CH_HT:LRC_CH_CR]});
        is_digit  = i_req.char_code inside {[LRC_CH_ZERO:LRC_CH_NINE]};
        digit     = i_req.char_code[3:0];
        cur_phase = (r_phase == PH_LEAD) ? PH_MIN : r_phase;
        digit_ms  = 20'(digit) * 20'(LRC_MS_PER_MIN);
        min_prod  = ({5'd0, r_min_ms} << 3) + ({5'd0, r_min_ms} << 1) + 68'(digit_ms);
        sec_prod  = 10'(r_sec) * 10'd10 + 10'(digit);
        frac_prod = 14'(r_frac) * 14'd10 + 14'(digit);

        n_phase  = r_phase;
        n_min_ms = r_min_ms;
        n_big    = r_big;
        n_sec    = r_sec;
        n_frac   = r_frac;
        n_fdig   = r_fdig;
        n_has    = r_has;
        n_space  = r_space;
        n_err    = r_err;

        if (!r_err) begin
            if (is_ws) begin
                if (r_phase != PH_LEAD) begin
                    n_space = 1'b1;
                end
            end else if (r_space) begin
                n_err = 1'b1;
            end else begin
                n_phase = cur_phase;
                case (cur_phase)
                    PH_MIN: begin
                        if (is_digit) begin
                            if (r_big || (min_prod[67:63] != 5'd0)) begin
                                n_big = 1'b1;
                            end else begin
                                n_min_ms = min_prod[62:0];
                            end
                            n_has = 1'b1;
                        end else if (i_req.char_code == LRC_CH_COLON && r_has) begin
                            n_phase = PH_SEC;
                            n_has   = 1'b0;
                        end else begin
                            n_err = 1'b1;
                        end
                    end
                    PH_SEC: begin
                        if (is_digit) begin
                            n_sec = (sec_prod > 10'(LRC_SEC_LIMIT)) ? LRC_SEC_LIMIT
                                                                   : sec_prod[5:0];
                            n_has = 1'b1;
                        end else if ((i_req.char_code == LRC_CH_DOT ||
                                      i_req.char_code == LRC_CH_COMMA) && r_has) begin
                            n_phase = PH_FRAC;
                            n_has   = 1'b0;
                        end else begin
                            n_err = 1'b1;
                        end
                    end
                    PH_FRAC: begin
                        if (is_digit && r_fdig < LRC_FRAC_MAX_DIG) begin
                            n_frac = frac_prod[9:0];
                            n_fdig = r_fdig + 2'd1;
                        end else begin
                            n_err = 1'b1;
                        end
                    end
                    default: begin
                        n_err = 1'b1;
                    end
                endcase
            end
        end

        case (n_fdig)
            2'd1:    frac_ms = 17'(n_frac) * 17'(LRC_FRAC_SCALE);
            2'd2:    frac_ms = 17'(n_frac) * 17'd10;
            default: frac_ms = 17'(n_frac);
        endcase
        rest_ms = 17'(n_sec) * 17'(LRC_MS_PER_SEC) + frac_ms;
        total   = {1'b0, r_min_ms} + 64'(rest_ms);

        case (n_phase)
            PH_SEC:  parts_ok = n_has;
            PH_FRAC: parts_ok = (n_fdig != 2'd0);
            default: parts_ok = 1'b0;
        endcase
        ok = !n_err && !n_big && parts_ok && (n_sec < LRC_SEC_LIMIT) && !total[63];

        o_res.valid_res = ok;
        o_res.time_ms   = ok ? total[62:0] : 63'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_LEAD;
            r_min_ms <= '0;
            r_big    <= 1'b0;
            r_sec    <= '0;
            r_frac   <= '0;
            r_fdig   <= '0;
            r_has    <= 1'b0;
            r_space  <= 1'b0;
            r_err    <= 1'b0;
        end else if (i_step) begin
            if (i_req.last) begin
                r_phase  <= PH_LEAD;
                r_min_ms <= '0;
                r_big    <= 1'b0;
                r_sec    <= '0;
                r_frac   <= '0;
                r_fdig   <= '0;
                r_has    <= 1'b0;
                r_space  <= 1'b0;
                r_err    <= 1'b0;
            end else begin
                r_phase  <= n_phase;
                r_min_ms <= n_min_ms;
                r_big    <= n_big;
                r_sec    <= n_sec;
                r_frac   <= n_frac;
                r_fdig   <= n_fdig;
                r_has    <= n_has;
                r_space  <= n_space;
                r_err    <= n_err;
            end
        end
    end

    `LRC_ASSERT_NOW(a_err_after_content, i_clk, i_rst_n, r_err, r_phase != PH_LEAD, "error flagged before any content")
    `LRC_ASSERT_NEXT(a_field_restart, i_clk, i_rst_n, i_step && i_req.last, (r_phase == PH_LEAD) && !r_err && !r_big && !r_space, "state not cleared after the last character")
    `LRC_ASSERT_NOW(a_big_in_minutes, i_clk, i_rst_n, r_big, r_phase != PH_LEAD, "minutes overflow without minutes digits")

endmodule

### hdl/lrc_timestamp_parser.sv
// Channel   Direction  Handshake               Payload
// s         in         i_s_tvalid/o_s_tready   i_s_tdata = char_code, i_s_tlast = last
// m         out        o_m_tvalid/i_m_tready   o_m_tdata = valid_res, time_ms
//
// One character request is taken per cycle while no stalled result holds back
// a last character; a field's result passes the input register, then the result register.
// The core parses each character in a combinational step with registered state.
// Reset is synchronous and active low; it returns the parser to the leading-whitespace state.
// A stalled result holds only the last character of the next field; other
// characters keep flowing into the parser.

`include "lrc_timestamp_parser_assert.svh"

module lrc_timestamp_parser
    import lrc_ts_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] char_code
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata    // [0] valid_res, [63:1] time_ms
);

    logic     r_in_valid;
    t_lrc_req r_in_req;
    logic     r_out_valid;
    t_lrc_res r_out_res;
    t_lrc_res core_res;
    logic     out_free;
    logic     step;

    assign out_free   = !r_out_valid || i_m_tready;
    assign step       = r_in_valid && (!r_in_req.last || out_free);
    assign o_s_tready = !r_in_valid || step;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_res;

    lrc_ts_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_req   (r_in_req),
        .o_res   (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_req.char_code <= i_s_tdata;
            r_in_req.last      <= i_s_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= step && r_in_req.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && r_in_req.last) begin
            r_out_res <= core_res;
        end
    end

    `LRC_ASSERT_NEXT(a_last_gives_result, i_clk, i_rst_n,
        step && r_in_req.last, r_out_valid, "last character did not produce a result")
    `LRC_ASSERT_NOW(a_invalid_is_zero, i_clk, i_rst_n,
        r_out_valid && !r_out_res.valid_res, r_out_res.time_ms == 63'd0,
        "invalid result carries a nonzero time")
    `LRC_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n,
        r_out_valid && !i_m_tready, !(step && r_in_req.last), "pending result overwritten")

endmodule

### sim/lrc_timestamp_parser_test.sv
`timescale 1ns / 100ps

module lrc_timestamp_parser_test;
    import lrc_ts_pkg::*;

    localparam logic [63:0] MAX_MS       = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [7:0]  CH_PLUS      = 8'h2B;
    localparam logic [7:0]  CH_MINUS     = 8'h2D;
    localparam logic [7:0]  CH_X         = 8'h78;
    localparam logic [7:0]  CH_VT        = 8'h0B;
    localparam logic [7:0]  CH_FF        = 8'h0C;
    localparam int          RANDOM_CHARS = 900;
    localparam int          CYCLE_LIMIT  = 600000;
    localparam int          HOLD_AT      = 300;
    localparam int          HOLD_CYCLES  = 400;

    typedef enum logic [2:0] {
        PH_LEAD,
        PH_MIN,
        PH_SEC,
        PH_FRAC
    } t_phase;

    typedef struct {
        t_lrc_req req;
        bit       wait_drain;
    } t_char_slot;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata = 8'h00;   // [7:0] char_code
    logic        i_s_tlast = 1'b0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [63:0] o_m_tdata;           // [0] valid_res, [63:1] time_ms

    t_char_slot  pending_chars[$];
    t_lrc_res    expected_times[$];
    logic [7:0]  field_buf[$];

    t_phase      ts_phase;
    logic [63:0] ts_minutes;
    logic [5:0]  ts_seconds;
    logic [9:0]  ts_fraction;
    logic [1:0]  ts_frac_digits;
    logic        ts_has_digit;
    logic        ts_space_seen;
    logic        ts_error;

    int errors = 0;
    int chars_taken = 0;
    int fields_valid = 0;
    int fields_rejected = 0;
    int cycles = 0;
    int random_chars = 0;
    int gap_left = 0;
    int stall_left = 0;
    bit long_hold_done = 1'b0;

    lrc_timestamp_parser u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic is_blank(input logic [7:0] c);
        return c == LRC_CH_SPACE || (c >= LRC_CH_HT && c <= LRC_CH_CR);
    endfunction

    task automatic ts_clear();
        ts_phase       = PH_LEAD;
        ts_minutes     = '0;
        ts_seconds     = '0;
        ts_fraction    = '0;
        ts_frac_digits = '0;
        ts_has_digit   = 1'b0;
        ts_space_seen  = 1'b0;
        ts_error       = 1'b0;
    endtask

    task automatic ts_take_char(input logic [7:0] c);
        logic        is_digit;
        logic [63:0] d;
        int          s;
        is_digit = c >= LRC_CH_ZERO && c <= LRC_CH_NINE;
        d = {56'd0, c - LRC_CH_ZERO};
        if (!ts_error) begin
            if (is_blank(c)) begin
                if (ts_phase != PH_LEAD)
                    ts_space_seen = 1'b1;
            end else if (ts_space_seen) begin
                ts_error = 1'b1;
            end else begin
                if (ts_phase == PH_LEAD)
                    ts_phase = PH_MIN;
                case (ts_phase)
                    PH_MIN: begin
                        if (is_digit) begin
                            if (ts_minutes > (MAX_MS - d) / 10)
                                ts_error = 1'b1;
                            else
                                ts_minutes = ts_minutes * 10 + d;
                            ts_has_digit = 1'b1;
                        end else if (c == LRC_CH_COLON && ts_has_digit) begin
                            ts_phase = PH_SEC;
                            ts_has_digit = 1'b0;
                        end else begin
                            ts_error = 1'b1;
                        end
                    end
                    PH_SEC: begin
                        if (is_digit) begin
                            s = int'(ts_seconds) * 10 + int'(d);
                            ts_seconds = (s > int'(LRC_SEC_LIMIT)) ? LRC_SEC_LIMIT : s[5:0];
                            ts_has_digit = 1'b1;
                        end else if ((c == LRC_CH_DOT || c == LRC_CH_COMMA) && ts_has_digit) begin
                            ts_phase = PH_FRAC;
                            ts_has_digit = 1'b0;
                        end else begin
                            ts_error = 1'b1;
                        end
                    end
                    default: begin
                        if (is_digit && ts_frac_digits < LRC_FRAC_MAX_DIG) begin
                            ts_fraction = ts_fraction * 10'd10 + d[9:0];
                            ts_frac_digits = ts_frac_digits + 2'd1;
                        end else begin
                            ts_error = 1'b1;
                        end
                    end
                endcase
            end
        end
    endtask

    function automatic t_lrc_res ts_field_time();
        t_lrc_res    res;
        logic        ok;
        logic [63:0] frac_ms;
        logic [63:0] rest;
        logic [63:0] total;
        ok = !ts_error;
        if (ts_phase == PH_SEC)
            ok = ok && ts_has_digit;
        else if (ts_phase == PH_FRAC)
            ok = ok && ts_frac_digits != 0;
        else
            ok = 1'b0;
        ok = ok && ts_seconds < LRC_SEC_LIMIT;
        total = '0;
        if (ok) begin
            frac_ms = 64'(ts_fraction);
            if (ts_frac_digits == 1)
                frac_ms = frac_ms * LRC_FRAC_SCALE;
            else if (ts_frac_digits == 2)
                frac_ms = frac_ms * (LRC_FRAC_SCALE / 10);
            rest = 64'(ts_seconds);
            rest = rest * LRC_MS_PER_SEC + frac_ms;
            if (ts_minutes > (MAX_MS - rest) / LRC_MS_PER_MIN)
                ok = 1'b0;
            else
                total = ts_minutes * LRC_MS_PER_MIN + rest;
        end
        res.valid_res = ok;
        res.time_ms = ok ? total[62:0] : '0;
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= 30)
            $display("mismatch at cycle %0d: %s", cycles, msg);
    endtask

    function automatic int pick_gap();
        int r;
        if (((chars_taken >> 7) % 3) == 0)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] rand_digit(input int hi);
        logic [7:0] v;
        v = 8'($urandom_range(0, hi));
        return LRC_CH_ZERO + v;
    endfunction

    function automatic logic [7:0] rand_blank();
        logic [7:0] v;
        v = 8'($urandom_range(8, 13));
        return (v == 8) ? LRC_CH_SPACE : v;
    endfunction

    task automatic flush_field(input bit drain, input bit is_random);
        t_char_slot slot;
        for (int i = 0; i < field_buf.size(); i++) begin
            slot.req.char_code = field_buf[i];
            slot.req.last = (i == field_buf.size() - 1);
            slot.wait_drain = drain && i == 0;
            pending_chars.insert(pending_chars.size(), slot);
        end
        if (is_random)
            random_chars += field_buf.size();
        field_buf.delete();
    endtask

    task automatic add_char(input logic [7:0] c);
        field_buf.insert(field_buf.size(), c);
    endtask

    task automatic queue_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_char(s[i]);
        flush_field(1'b0, 1'b0);
    endtask

    task automatic queue_random_field(input bit drain);
        int         n;
        int         r;
        logic [7:0] c;
        if ($urandom_range(0, 99) < 85) begin
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
            repeat (n) add_char(rand_blank());
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 19) : $urandom_range(1, 3);
            repeat (n) add_char(rand_digit(9));
            add_char(LRC_CH_COLON);
            if ($urandom_range(0, 4) != 0) begin
                add_char(rand_digit(5));
                add_char(rand_digit(9));
            end else begin
                repeat ($urandom_range(1, 3)) add_char(rand_digit(9));
            end
            if ($urandom_range(0, 9) < 6) begin
                add_char($urandom_range(0, 1) ? LRC_CH_DOT : LRC_CH_COMMA);
                r = $urandom_range(0, 19);
                n = (r == 0) ? 0 : (r == 1) ? 4 : $urandom_range(1, 3);
                repeat (n) add_char(rand_digit(9));
            end
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 2)) add_char(rand_blank());
            r = $urandom_range(0, 99);
            if (r < 12) begin
                c = 8'($urandom_range(0, 255));
                field_buf[$urandom_range(0, field_buf.size() - 1)] = c;
            end else if (r < 17) begin
                field_buf.insert($urandom_range(0, field_buf.size() - 1),
                                 $urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
            end else if (r < 21) begin
                field_buf.insert($urandom_range(1, field_buf.size() - 1), rand_blank());
            end
        end else if ($urandom_range(0, 2) == 0) begin
            repeat ($urandom_range(1, 3)) add_char(rand_blank());
        end else begin
            repeat ($urandom_range(1, 6)) begin
                c = 8'($urandom_range(0, 255));
                add_char(c);
            end
        end
        flush_field(drain, 1'b1);
    endtask

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_char_slot slot;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            i_s_tdata <= 8'h00;
            i_s_tlast <= 1'b0;
            gap_left = 0;
            ts_clear();
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                chars_taken++;
                ts_take_char(i_s_tdata);
                if (i_s_tlast) begin
                    expected_times.insert(expected_times.size(), ts_field_time());
                    ts_clear();
                end
            end
            if (!(i_s_tvalid && !o_s_tready)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_s_tvalid <= 1'b0;
                end else if (pending_chars.size() > 0 &&
                             !(pending_chars[0].wait_drain && expected_times.size() > 0)) begin
                    slot = pending_chars.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tdata <= slot.req.char_code;
                    i_s_tlast <= slot.req.last;
                    gap_left = pick_gap();
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            stall_left = 0;
            long_hold_done = 1'b0;
        end else if (!long_hold_done && chars_taken >= HOLD_AT) begin
            long_hold_done = 1'b1;
            stall_left = HOLD_CYCLES;
            i_m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
            stall_left = pick_gap();
        end
    end

    always @(posedge i_clk) begin
        t_lrc_res got;
        t_lrc_res want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = t_lrc_res'(o_m_tdata);
            if (expected_times.size() == 0) begin
                report_mismatch($sformatf("result %0h with no field pending", o_m_tdata));
            end else begin
                want = expected_times.pop_front();
                if (want.valid_res)
                    fields_valid++;
                else
                    fields_rejected++;
                if (got.valid_res !== want.valid_res)
                    report_mismatch($sformatf("valid_res %b, expected %b",
                                              got.valid_res, want.valid_res));
                if (got.time_ms !== want.time_ms)
                    report_mismatch($sformatf("time_ms %0d, expected %0d",
                                              got.time_ms, want.time_ms));
            end
        end
    end

    initial begin
        queue_text("0:00");
        queue_text("99:59.999");
        queue_text(" 1:02.5 ");
        queue_text("\t12:34,56\n");
        field_buf = '{CH_VT, rand_digit(0), LRC_CH_COLON, rand_digit(7), CH_FF, LRC_CH_CR};
        flush_field(1'b0, 1'b0);
        queue_text("007:05.1");
        queue_text("-0:00");
        queue_text("+1:00");
        queue_text(" ");
        queue_text("1: 2");
        queue_text("1:02.");
        queue_text("1");
        queue_text(":12");
        queue_text("1:60");
        queue_text("1:59.1234");
        queue_text("1::2");
        queue_text("1:2.3.4");
        field_buf = '{rand_digit(9), LRC_CH_COLON, rand_digit(9), CH_X};
        flush_field(1'b0, 1'b0);
        field_buf = '{8'hFF, 8'h80, 8'h00};
        flush_field(1'b0, 1'b0);
        queue_text("9223372036854775808:00");
        queue_text("9223372036854775807:00");
        queue_text("153722867280912:55.807");
        queue_text("153722867280912:55.808");
        queue_random_field(1'b1);
        while (random_chars < RANDOM_CHARS)
            queue_random_field($urandom_range(0, 24) == 0);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_chars.size() != 0 || i_s_tvalid)
            @(posedge i_clk);
        while (expected_times.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Checked %0d timestamp fields from %0d characters: %0d parsed, %0d rejected.",
                 fields_valid + fields_rejected, chars_taken, fields_valid, fields_rejected);
        $display("Traffic mixed well-formed fields, broken fields and byte noise under stalls.");
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
